>>> src/drr_pkg.sv
`timescale 1ns / 1ps
package drr_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_DQ_FIFO,
		ST_DQ_FLOW,
		ST_DQ_PKT,
		ST_RESP
	} state_t;

	localparam logic       KIND_ENQ = 1'b0;
	localparam logic       KIND_REQ = 1'b1;

	localparam logic [1:0] STATUS_SENT    = 2'd0;
	localparam logic [1:0] STATUS_NONE    = 2'd1;
	localparam logic [1:0] STATUS_ENQ     = 2'd2;
	localparam logic [1:0] STATUS_DROPPED = 2'd3;

	localparam logic [2:0] REG_FLOWS     = 3'd0;
	localparam logic [2:0] REG_QUANTUM0  = 3'd1;
	localparam logic [2:0] REG_QUANTUM3  = 3'd4;

	localparam int          NUM_QUANTUM = 4;
	localparam logic [16:0] UNIT        = 17'd256;

	typedef struct packed {
		logic [2:0]                    flows_in_use;
		logic [NUM_QUANTUM-1:0][15:0] quantum;
	} cfg_t;

endpackage

>>> src/deficit_round_robin_scheduler_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tuser: kind; tdata: flow_id, seq_num, arrival_tick
// m_       out  m_tvalid/m_tready    tuser: status; tdata: out_flow, out_seq_num,
//                                    out_arrival_tick
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat at a time through a read-modify-write sequencer over three RAMs with
// registered reads (packet store, flow table, active list). Enqueue: ST_ENQ;
// service request: ST_DQ_FIFO, ST_DQ_FLOW, ST_DQ_PKT; drop or empty request:
// straight to ST_RESP. Reset clears the per-flow valid bits at once; no clearing pass.
// A result waiting on m_ does not block the next input beat; only the
// following result load waits for m_tready.
module deficit_round_robin_scheduler_core
	import drr_pkg::*;
#(
	parameter int NUM_FLOWS   = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // flow_id[1:0], seq_num[33:2], arrival_tick[65:34], zeros
	input  logic [0:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // out_flow[1:0], out_seq_num[33:2], out_arrival_tick[65:34]
	output logic [1:0]  m_tuser,  // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int FLW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam int FCW = $clog2(NUM_FLOWS + 1);
	localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int PD  = NUM_FLOWS * QUEUE_DEPTH;
	localparam int AW  = (PD > 1) ? $clog2(PD) : 1;
	localparam int FSW = 1 + 17 + QCW + 2 * QW;

	localparam logic [FLW-1:0] LAST_SLOT = FLW'(NUM_FLOWS - 1);
	localparam logic [QW-1:0]  LAST_PTR  = QW'(QUEUE_DEPTH - 1);
	localparam logic [QCW-1:0] QFULL     = QCW'(QUEUE_DEPTH);
	localparam logic [FCW:0]   NF_SUM    = (FCW + 1)'(NUM_FLOWS);

	cfg_t cfg;

	state_t state_q, state_d;

	logic [FLW-1:0] flow_q, dq_flow_q;
	logic [31:0]    seq_q, tick_q;
	logic [FLW-1:0] act_head_q;
	logic [FCW-1:0] act_count_q;
	logic [NUM_FLOWS-1:0] fvalid_q;

	logic [1:0]  res_status_q;
	logic [1:0]  res_flow_q;
	logic [31:0] res_seq_q, res_tick_q;
	logic        m_valid_q;
	logic [1:0]  m_status_q, m_flow_q;
	logic [31:0] m_seq_q, m_tick_q;

	logic          accept;
	logic          in_kind;
	logic [6:0]    in_flow7;
	logic [6:0]    limit7;
	logic          in_drop;

	// RAM ports
	logic           pk_we, pk_re;
	logic [AW-1:0]  pk_waddr, pk_raddr;
	logic [63:0]    pk_rdata;
	logic           fs_we, fs_re;
	logic [FLW-1:0] fs_waddr, fs_raddr;
	logic [FSW-1:0] fs_wdata, fs_rdata;
	logic           af_we, af_re;
	logic [FLW-1:0] af_waddr, af_raddr;
	logic [FLW-1:0] af_wdata, af_rdata;

	// flow table view
	logic [FLW-1:0] cur_flow;
	logic [FSW-1:0] fs_cur;
	logic [QW-1:0]  fs_head, fs_tail, head_nx, tail_nx;
	logic [QCW-1:0] fs_count, count_dec;
	logic [16:0]    fs_credit, credit_fill, credit_left;
	logic           fs_active;
	logic [6:0]     cur_flow7;
	logic [15:0]    quantum_raw;
	logic [16:0]    quantum_eff;

	logic [FCW:0]   tail_sum;
	logic [FLW-1:0] tail_slot, head_slot_nx;

	logic           enq_full;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_kind  = s_tuser[0];
	assign in_flow7 = {5'd0, s_tdata[1:0]};
	assign limit7   = ({4'd0, cfg.flows_in_use} < 7'(NUM_FLOWS)) ?
	                  {4'd0, cfg.flows_in_use} : 7'(NUM_FLOWS);
	assign in_drop  = (in_flow7 >= limit7);

	drr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	drr_ram #(.WIDTH(64), .DEPTH(PD)) u_pkt_ram (
		.clk   (clk),
		.we    (pk_we),
		.waddr (pk_waddr),
		.wdata ({tick_q, seq_q}),
		.re    (pk_re),
		.raddr (pk_raddr),
		.rdata (pk_rdata)
	);

	drr_ram #(.WIDTH(FSW), .DEPTH(NUM_FLOWS)) u_flow_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.re    (fs_re),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	drr_ram #(.WIDTH(FLW), .DEPTH(NUM_FLOWS)) u_act_ram (
		.clk   (clk),
		.we    (af_we),
		.waddr (af_waddr),
		.wdata (af_wdata),
		.re    (af_re),
		.raddr (af_raddr),
		.rdata (af_rdata)
	);

	// An entry never written reads as the reset value: all zero.
	assign cur_flow  = (state_q == ST_ENQ) ? flow_q : dq_flow_q;
	assign fs_cur    = fvalid_q[cur_flow] ? fs_rdata : '0;
	assign fs_head   = fs_cur[QW-1:0];
	assign fs_tail   = fs_cur[2*QW-1:QW];
	assign fs_count  = fs_cur[2*QW+QCW-1:2*QW];
	assign fs_credit = fs_cur[2*QW+QCW+16:2*QW+QCW];
	assign fs_active = fs_cur[FSW-1];

	assign head_nx   = (fs_head == LAST_PTR) ? '0 : fs_head + 1'b1;
	assign tail_nx   = (fs_tail == LAST_PTR) ? '0 : fs_tail + 1'b1;
	assign count_dec = fs_count - 1'b1;
	assign enq_full  = (fs_count >= QFULL);

	assign cur_flow7   = 7'(cur_flow);
	assign quantum_raw = cfg.quantum[cur_flow7[1:0]];
	assign quantum_eff = ({1'b0, quantum_raw} < UNIT) ? UNIT : {1'b0, quantum_raw};
	assign credit_fill = (fs_credit < UNIT) ? fs_credit + quantum_eff : fs_credit;
	assign credit_left = credit_fill - UNIT;

	// back of the active list: (head + count) mod NUM_FLOWS, sum below twice the depth
	assign tail_sum     = (FCW + 1)'(act_head_q) + (FCW + 1)'(act_count_q);
	assign tail_slot    = (tail_sum >= NF_SUM) ? FLW'(tail_sum - NF_SUM) : FLW'(tail_sum);
	assign head_slot_nx = (act_head_q == LAST_SLOT) ? '0 : act_head_q + 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_kind == KIND_ENQ) begin
						state_d = in_drop ? ST_RESP : ST_ENQ;
					end else begin
						state_d = (act_count_q == '0) ? ST_RESP : ST_DQ_FIFO;
					end
				end
			end
			ST_ENQ:     state_d = ST_RESP;
			ST_DQ_FIFO: state_d = ST_DQ_FLOW;
			ST_DQ_FLOW: state_d = (fs_count == '0) ? ST_RESP : ST_DQ_PKT;
			ST_DQ_PKT:  state_d = ST_RESP;
			ST_RESP: begin
				if (!m_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pk_we    = 1'b0;
		pk_re    = 1'b0;
		pk_waddr = AW'(AW'(flow_q) * AW'(QUEUE_DEPTH)) + AW'(fs_tail);
		pk_raddr = AW'(AW'(dq_flow_q) * AW'(QUEUE_DEPTH)) + AW'(fs_head);
		fs_we    = 1'b0;
		fs_re    = 1'b0;
		fs_waddr = cur_flow;
		fs_raddr = FLW'(in_flow7);
		fs_wdata = fs_cur;
		af_we    = 1'b0;
		af_re    = 1'b0;
		af_waddr = tail_slot;
		af_wdata = cur_flow;
		af_raddr = act_head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_kind == KIND_ENQ && !in_drop) begin
					fs_re = 1'b1;
				end
				if (accept && in_kind == KIND_REQ) begin
					af_re = 1'b1;
				end
			end
			ST_ENQ: begin
				if (!enq_full) begin
					pk_we    = 1'b1;
					fs_we    = 1'b1;
					fs_wdata = {1'b1, fs_active ? fs_credit : 17'd0,
					            fs_count + 1'b1, tail_nx, fs_head};
					af_we    = !fs_active;
				end
			end
			ST_DQ_FIFO: begin
				fs_re    = 1'b1;
				fs_raddr = af_rdata;
			end
			ST_DQ_FLOW: begin
				fs_we = 1'b1;
				if (fs_count == '0) begin
					fs_wdata = {1'b0, 17'd0, fs_count, fs_tail, fs_head};
				end else begin
					pk_re = 1'b1;
					if (count_dec == '0) begin
						fs_wdata = {1'b0, 17'd0, count_dec, fs_tail, head_nx};
					end else begin
						fs_wdata = {1'b1, credit_left, count_dec, fs_tail, head_nx};
						// rotate: the slot freed at the front becomes the back
						af_we    = (credit_left < UNIT);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_head_q  <= '0;
			act_count_q <= '0;
			fvalid_q    <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fs_we) begin
				fvalid_q[fs_waddr] <= 1'b1;
			end
			if (state_q == ST_ENQ && !enq_full && !fs_active) begin
				act_count_q <= act_count_q + 1'b1;
			end
			if (state_q == ST_DQ_FLOW) begin
				if (fs_count == '0 || count_dec == '0) begin
					act_head_q  <= head_slot_nx;
					act_count_q <= act_count_q - 1'b1;
				end else if (credit_left < UNIT) begin
					act_head_q <= head_slot_nx;
				end
			end
			if (state_q == ST_RESP && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flow_q     <= FLW'(in_flow7);
			seq_q      <= s_tdata[33:2];
			tick_q     <= s_tdata[65:34];
			res_flow_q <= 2'd0;
			res_seq_q  <= 32'd0;
			res_tick_q <= 32'd0;
			if (in_kind == KIND_ENQ) begin
				res_status_q <= STATUS_DROPPED;
			end else begin
				res_status_q <= STATUS_NONE;
			end
		end
		case (state_q)
			ST_ENQ: begin
				res_status_q <= enq_full ? STATUS_DROPPED : STATUS_ENQ;
			end
			ST_DQ_FIFO: begin
				dq_flow_q <= af_rdata;
			end
			ST_DQ_FLOW: begin
				res_status_q <= (fs_count == '0) ? STATUS_NONE : STATUS_SENT;
				res_flow_q   <= (fs_count == '0) ? 2'd0 : cur_flow7[1:0];
			end
			ST_DQ_PKT: begin
				res_seq_q  <= pk_rdata[31:0];
				res_tick_q <= pk_rdata[63:32];
			end
			default: begin
			end
		endcase
		if (state_q == ST_RESP && (!m_valid_q || m_tready)) begin
			m_status_q <= res_status_q;
			m_flow_q   <= res_flow_q;
			m_seq_q    <= res_seq_q;
			m_tick_q   <= res_tick_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {6'd0, m_tick_q, m_seq_q, m_flow_q};

endmodule

>>> src/drr_ram.sv
`timescale 1ns / 1ps
module drr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/drr_cfg.sv
`timescale 1ns / 1ps
module drr_cfg
	import drr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic [1:0] qsel;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;
	assign qsel      = 2'(cfg_index - REG_QUANTUM0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flows_in_use <= 3'd4;
			for (int i = 0; i < NUM_QUANTUM; i++) begin
				cfg_q.quantum[i] <= 16'd256;
			end
		end else if (cfg_valid) begin
			case (cfg_index) inside
				REG_FLOWS: begin
					cfg_q.flows_in_use <= cfg_data[2:0];
				end
				[REG_QUANTUM0:REG_QUANTUM3]: begin
					cfg_q.quantum[qsel] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
